### rtl/bfas_pkg.sv
// Package with shared types, constants and a leading-zero count function for the binary32 adder.
package bfas_pkg;

    localparam logic [31:0] QuietNan = 32'h7FC00000;
    localparam logic [31:0] SignBit  = 32'h80000000;

    typedef struct packed {
        logic        special;
        logic [31:0] special_bits;
        logic        sres;
        logic [8:0]  exp;
        logic [27:0] sum;
    } bfas_mid_t;

    function automatic logic [4:0] lead_zeros(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/binary32_float_add_sub.sv
// Top level of the pipelined binary32 adder and subtractor.
// Each input transfer passes through the stage registers (unpack, align and add, carry fold, round) to the m_ side.
// Throughput: one transfer per cycle; the pipeline advances whenever its last
// stage is empty or is being taken, and stalls as a whole otherwise.
// Reset: aresetn clears all valid bits synchronously; payload is not reset.
module binary32_float_add_sub (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action[0], operand_a[32:1], operand_b[64:33], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sum_bits[31:0]
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic        sp1_reg;
    logic [31:0] spb1_reg;
    logic        sa1_reg, sb1_reg, swap1_reg;
    logic [7:0]  xa1_reg, xb1_reg;
    logic [26:0] ma1_reg, mb1_reg;
    logic [7:0]  d1_reg;

    bfas_pkg::bfas_mid_t st2_reg, st2_next;
    bfas_pkg::bfas_mid_t st3_reg, st3_next;
    logic [4:0]  lz3_reg;
    logic [31:0] res4_reg, res4_next;

    assign adv      = !v4_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v4_reg;
    assign m_tdata  = res4_reg;

    // Stage 1: unpack, special cases, exponent difference.
    logic [31:0] a_in, b_in;
    logic [7:0]  xa, xb;
    logic        nan_a, nan_b, inf_a, inf_b;
    logic        sp1_next;
    logic [31:0] spb1_next;
    logic [8:0]  dab;
    logic        swap1;
    always_comb begin
        a_in = s_tdata[32:1];
        b_in = s_tdata[64:33] ^ (s_tdata[0] ? bfas_pkg::SignBit : 32'd0);
        xa = a_in[30:23];
        xb = b_in[30:23];
        nan_a = (xa == 8'hFF) && (a_in[22:0] != 23'd0);
        nan_b = (xb == 8'hFF) && (b_in[22:0] != 23'd0);
        inf_a = (xa == 8'hFF) && !nan_a;
        inf_b = (xb == 8'hFF) && !nan_b;
        dab = {1'b0, xa} - {1'b0, xb};
        swap1 = dab[8];
        sp1_next = 1'b1;
        spb1_next = 32'd0;
        if (nan_a || nan_b) begin
            spb1_next = bfas_pkg::QuietNan;
        end else if (inf_a && inf_b) begin
            spb1_next = (a_in[31] == b_in[31]) ? a_in : bfas_pkg::QuietNan;
        end else if (inf_a) begin
            spb1_next = a_in;
        end else if (inf_b) begin
            spb1_next = b_in;
        end else if (xa == 8'd0 && xb == 8'd0) begin
            spb1_next = (a_in[31] && b_in[31]) ? bfas_pkg::SignBit : 32'd0;
        end else if (xa == 8'd0) begin
            spb1_next = b_in;
        end else if (xb == 8'd0) begin
            spb1_next = a_in;
        end else if (!swap1 && dab[7:0] >= 8'd32) begin
            spb1_next = a_in;
        end else if (swap1 && (9'd0 - dab) >= 9'd32) begin
            spb1_next = b_in;
        end else begin
            sp1_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
        if (adv) begin
            sp1_reg   <= sp1_next;
            spb1_reg  <= spb1_next;
            sa1_reg   <= a_in[31];
            sb1_reg   <= b_in[31];
            xa1_reg   <= xa;
            xb1_reg   <= xb;
            swap1_reg <= swap1;
            ma1_reg   <= {1'b1, a_in[22:0], 3'b000};
            mb1_reg   <= {1'b1, b_in[22:0], 3'b000};
            d1_reg    <= swap1 ? 8'(9'd0 - dab) : dab[7:0];
        end
    end

    // Stage 2: align the smaller operand and add or subtract.
    logic [26:0] big, small_m, shifted, lostmask;
    logic        sbig, ssmall;
    logic [27:0] raw;
    always_comb begin
        big     = swap1_reg ? mb1_reg : ma1_reg;
        small_m = swap1_reg ? ma1_reg : mb1_reg;
        sbig    = swap1_reg ? sb1_reg : sa1_reg;
        ssmall  = swap1_reg ? sa1_reg : sb1_reg;
        lostmask = (d1_reg >= 8'd27) ? {27{1'b1}} : ~({27{1'b1}} << d1_reg[4:0]);
        shifted = (d1_reg >= 8'd27) ? 27'd0 : (small_m >> d1_reg[4:0]);
        shifted[0] = shifted[0] | ((small_m & lostmask) != 27'd0);
        st2_next.special      = sp1_reg;
        st2_next.special_bits = spb1_reg;
        st2_next.exp          = {1'b0, swap1_reg ? xb1_reg : xa1_reg};
        st2_next.sres         = sbig;
        if (sbig == ssmall) begin
            raw = {1'b0, big} + {1'b0, shifted};
        end else if (big >= shifted) begin
            raw = {1'b0, big} - {1'b0, shifted};
        end else begin
            raw = {1'b0, shifted} - {1'b0, big};
            st2_next.sres = ssmall;
        end
        st2_next.sum = raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            st2_reg <= st2_next;
        end
    end

    // Stage 3: fold a carry out and count leading zeros.
    always_comb begin
        st3_next = st2_reg;
        if (st2_reg.sum[27]) begin
            st3_next.sum = {1'b0, st2_reg.sum[27:2], st2_reg.sum[1] | st2_reg.sum[0]};
            st3_next.exp = st2_reg.exp + 9'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            st3_reg <= st3_next;
            lz3_reg <= bfas_pkg::lead_zeros(st3_next.sum[26:0]);
        end
    end

    // Stage 4: normalize, round and pack.
    logic [8:0]  lim, sh;
    logic [26:0] norm;
    logic [8:0]  e4;
    logic [24:0] trunc;
    logic [2:0]  rb;
    always_comb begin
        lim   = (st3_reg.exp > 9'd1) ? st3_reg.exp - 9'd1 : 9'd0;
        sh    = ({4'd0, lz3_reg} < lim) ? {4'd0, lz3_reg} : lim;
        norm  = st3_reg.sum[26:0] << sh[4:0];
        e4    = st3_reg.exp - sh;
        rb    = norm[2:0];
        trunc = {1'b0, norm[26:3]};
        if (rb > 3'd4 || (rb == 3'd4 && trunc[0])) begin
            trunc = trunc + 25'd1;
        end
        if (trunc[24]) begin
            trunc = trunc >> 1;
            e4 = e4 + 9'd1;
        end
        if (st3_reg.special) begin
            res4_next = st3_reg.special_bits;
        end else if (st3_reg.sum == 28'd0) begin
            res4_next = 32'd0;
        end else if (!trunc[23]) begin
            res4_next = {st3_reg.sres, 31'd0};
        end else if (e4 >= 9'd255) begin
            res4_next = {st3_reg.sres, 8'hFF, 23'd0};
        end else begin
            res4_next = {st3_reg.sres, e4[7:0], trunc[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
        if (adv) begin
            res4_reg <= res4_next;
        end
    end

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed during a stall");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && !v1_reg && !v2_reg && !v3_reg) |=> !v4_reg || $past(v4_reg))
        else $error("result appeared without a transfer");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while pipeline output empty");
`endif

endmodule
